// ----- hdl/varint_palette_index_decoder_macros.svh -----
// Assertion macros shared by the varint palette index decoder modules.
`ifndef VARINT_PALETTE_INDEX_DECODER_MACROS_SVH
`define VARINT_PALETTE_INDEX_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define VPID_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vpid assertion failed");
// Checks that a condition never holds outside reset.
`define VPID_ASSERT_NEVER(label, clk, rst_n, cond) \
  `VPID_ASSERT(label, clk, rst_n, !(cond))
`else
`define VPID_ASSERT(label, clk, rst_n, prop)
`define VPID_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- hdl/vpid_pkg.sv -----
// Types and constants of the varint palette index decoder.
`default_nettype none
package vpid_pkg;

  // Width of the index counters.
  localparam int CountWidth = 24;

  // Configuration port.
  localparam int CfgIdxWidth  = 8;
  localparam int CfgDataWidth = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_INDEX_COUNT     = 8'd0,
    CFG_PALETTE_ENTRIES = 8'd1
  } cfg_reg_e;

  // Palette size and decoding widths.
  localparam int PaletteWidth = 17;
  localparam logic [PaletteWidth-1:0] PaletteMax = 17'h10000;
  localparam int GroupWidth = 7;
  localparam int AccWidth   = 32;
  localparam int PosWidth   = 3;
  localparam logic [PosWidth-1:0] MaxPos = 3'd4;
  localparam int IndexWidth = 16;

  // Queue between front and back; the depth must be a power of two.
  localparam int QueueDepth    = 2;
  localparam int QueuePtrWidth = $clog2(QueueDepth);
  localparam int QueueCntWidth = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    STATUS_INDEX     = 2'd0,
    STATUS_TRUNCATED = 2'd1,
    STATUS_OVERFLOW  = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [IndexWidth-1:0] palette_index;
    status_e               status;
    logic                  last;
  } out_item_t;

  // A byte after classification by the front.
  typedef struct packed {
    logic [GroupWidth-1:0] group;
    logic                  cont;
    logic                  start;
    logic                  eod;
  } class_t;

  typedef struct packed {
    logic [CountWidth-1:0]   index_count;
    logic [PaletteWidth-1:0] palette_entries;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hdl/vpid_front.sv -----
// Front of the decoder: accepts bytes, classifies them and queues them.
`default_nettype none
`include "varint_palette_index_decoder_macros.svh"
module vpid_front
  import vpid_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          head_valid_o,
  output class_t        head_o,
  input  wire logic     pop_i
);

  class_t                   entry_q [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntWidth-1:0] count_q, count_d;
  logic                     push;
  class_t                   cls;

  // Split the byte into its group and continuation bit.
  always_comb begin
    cls.group = in_item_i.data_byte[GroupWidth-1:0];
    cls.cont  = in_item_i.data_byte[7];
    cls.start = in_item_i.block_start;
    cls.eod   = in_item_i.end_of_data;
  end

  assign in_ready_o   = (count_q != QueueCntWidth'(QueueDepth));
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

  `VPID_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && (count_q == '0))
  `VPID_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= QueueCntWidth'(QueueDepth))
  `VPID_ASSERT(a_no_push_full, clk_i, rst_ni, (count_q == QueueCntWidth'(QueueDepth)) |-> !push)

endmodule
`default_nettype wire

// ----- hdl/vpid_back.sv -----
// Back of the decoder: builds varint values and emits indices and errors.
`default_nettype none
`include "varint_palette_index_decoder_macros.svh"
module vpid_back
  import vpid_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   cfg_i,
  input  wire logic   head_valid_i,
  input  wire class_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output out_item_t   out_item_o
);

  // Places a group at its position in the accumulator.
  function automatic logic [AccWidth-1:0] group_shift(logic [GroupWidth-1:0] g,
                                                      logic [PosWidth-1:0] pos);
    logic [AccWidth-1:0] r;
    case (pos)
      3'd0:    r = {25'b0, g};
      3'd1:    r = {18'b0, g, 7'b0};
      3'd2:    r = {11'b0, g, 14'b0};
      3'd3:    r = {4'b0, g, 21'b0};
      default: r = {g[3:0], 28'b0};
    endcase
    return r;
  endfunction

  logic [AccWidth-1:0]     acc_q, acc_d, acc_e, acc_n;
  logic [PosWidth-1:0]     pos_q, pos_d, pos_e;
  logic [CountWidth-1:0]   done_q, done_d, done_e, done_inc;
  logic                    fin_q, fin_d, fin_e;
  logic                    pend_q, pend_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;
  logic [PaletteWidth-1:0] pal;
  logic                    slot_free;
  logic                    emit;
  logic                    trunc2;
  logic                    out_of_range;
  out_item_t               res;
  out_item_t               trunc_item;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = head_valid_i && slot_free && !pend_q;

  // A block start clears the decoding state before the byte is used.
  always_comb begin
    acc_e    = head_i.start ? '0 : acc_q;
    pos_e    = head_i.start ? '0 : pos_q;
    done_e   = head_i.start ? '0 : done_q;
    fin_e    = head_i.start ? 1'b0 : fin_q;
    pal      = (cfg_i.palette_entries > PaletteMax) ? PaletteMax : cfg_i.palette_entries;
    acc_n    = acc_e | group_shift(head_i.group, pos_e);
    done_inc = done_e + 1'b1;
    out_of_range = (|acc_n[AccWidth-1:PaletteWidth]) || (acc_n[PaletteWidth-1:0] >= pal);
    trunc_item.palette_index = '0;
    trunc_item.status        = STATUS_TRUNCATED;
    trunc_item.last          = 1'b1;
  end

  // Decode step for the item at the head of the queue.
  always_comb begin
    acc_d  = acc_q;
    pos_d  = pos_q;
    done_d = done_q;
    fin_d  = fin_q;
    emit   = 1'b0;
    trunc2 = 1'b0;
    res.palette_index = '0;
    res.status        = STATUS_INDEX;
    res.last          = 1'b0;
    if (pop_o) begin
      acc_d  = acc_e;
      pos_d  = pos_e;
      done_d = done_e;
      fin_d  = fin_e;
      if (fin_e) begin
        // A finished block ignores the byte.
      end else if (pal == '0) begin
        emit       = 1'b1;
        res.status = STATUS_RANGE;
        res.last   = 1'b1;
        fin_d      = 1'b1;
      end else if (done_e >= cfg_i.index_count) begin
        fin_d = 1'b1;
      end else if (!head_i.cont) begin
        acc_d = '0;
        pos_d = '0;
        emit  = 1'b1;
        if (out_of_range) begin
          res.status = STATUS_RANGE;
          res.last   = 1'b1;
          fin_d      = 1'b1;
        end else begin
          done_d            = done_inc;
          res.palette_index = acc_n[IndexWidth-1:0];
          if (done_inc == cfg_i.index_count) begin
            res.last = 1'b1;
            fin_d    = 1'b1;
          end else if (head_i.eod) begin
            trunc2 = 1'b1;
            fin_d  = 1'b1;
          end
        end
      end else if (pos_e >= MaxPos) begin
        emit       = 1'b1;
        res.status = STATUS_OVERFLOW;
        res.last   = 1'b1;
        fin_d      = 1'b1;
      end else begin
        acc_d = acc_n;
        pos_d = pos_e + 1'b1;
        if (head_i.eod) begin
          emit  = 1'b1;
          res   = trunc_item;
          fin_d = 1'b1;
        end
      end
    end
  end

  // Output register; a pending truncation item goes out after its index.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pend_d      = pend_q;
    if (slot_free) begin
      if (pend_q) begin
        out_valid_d = 1'b1;
        out_d       = trunc_item;
        pend_d      = 1'b0;
      end else begin
        out_valid_d = pop_o && emit;
        out_d       = res;
        pend_d      = pop_o && trunc2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pos_q       <= '0;
      done_q      <= '0;
      fin_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      done_q      <= done_d;
      fin_q       <= fin_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `VPID_ASSERT(a_pend_has_out, clk_i, rst_ni, pend_q |-> out_valid_q)
  `VPID_ASSERT(a_last_ends_block, clk_i, rst_ni, (pop_o && emit && res.last) |=> fin_q)
  `VPID_ASSERT(a_pend_no_rise_stalled, clk_i, rst_ni,
               (out_valid_q && !out_ready_i && !pend_q) |=> !pend_q)

endmodule
`default_nettype wire

// ----- hdl/varint_palette_index_decoder.sv -----
// A byte passes through the byte queue and the output register before its result is valid.
// Throughput: one byte per cycle while the queue has room and the output is not held off;
// an index and a truncation from one byte leave in turn through the single output register of the back end.
// Reset clears the configuration, the decoding state, the byte queue and the output
// valid flag; the block is ready for bytes as soon as reset is released.
// Top level of the varint palette index decoder.
`default_nettype none
module varint_palette_index_decoder
  import vpid_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire in_item_t                in_item_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output out_item_t                    out_item_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  cfg_t   cfg_q, cfg_d;
  logic   head_valid;
  class_t head;
  logic   pop;

  // Configuration registers; unknown indices are ignored.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INDEX_COUNT:     cfg_d.index_count     = cfg_data_i[CountWidth-1:0];
        CFG_PALETTE_ENTRIES: cfg_d.palette_entries = cfg_data_i[PaletteWidth-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  vpid_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  vpid_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the varint palette index decoder.
`timescale 1ns / 1ps

module tb_top;
  import vpid_pkg::*;

  localparam int StallLimit   = 3000;
  localparam int SettleCycles = 6;
  localparam int HoldCycles   = 80;
  localparam int ReportLimit  = 10;

  // One byte of the directed table, or a register setting between bytes.
  typedef struct {
    bit                is_cfg;
    logic [23:0]       count;
    logic [16:0]       pal;
    in_item_t          it;
    int                n;
    out_item_t         r0;
    out_item_t         r1;
  } row_t;

  // Results typed in by hand for one byte; a negative count means use the decoder copy.
  typedef struct {
    int        n;
    out_item_t r0;
    out_item_t r1;
  } typed_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready_o;
  in_item_t                in_item   = '0;
  logic                    out_valid_o;
  logic                    out_ready = 1'b0;
  out_item_t               out_item_o;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data  = '0;

  // Decoder copy: registers and block state.
  logic [23:0] m_count   = '0;
  logic [16:0] m_pal     = '0;
  logic [31:0] acc_m     = '0;
  logic [2:0]  grp_pos   = '0;
  logic [23:0] idx_done  = '0;
  bit          blk_done  = 1'b0;

  out_item_t   decoded_q[$];
  out_item_t   step_q[$];
  bit          step_worked;
  typed_t      typed_q[$];
  row_t        plan[$];

  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit rx_hold_req = 1'b0;
  int rx_hold_left = 0;

  int faults        = 0;
  int bytes_taken   = 0;
  int worked_items  = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int stall_cycles  = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  varint_palette_index_decoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_item_t mk(logic [15:0] idx, status_e st, logic lst);
    out_item_t r;
    r.palette_index = idx;
    r.status        = st;
    r.last          = lst;
    return r;
  endfunction

  // Works out the results of one byte and advances the decoder copy.
  function void decode_byte(input in_item_t it);
    logic [16:0] pal_eff;
    logic [31:0] grp;
    logic [31:0] v;
    step_q.delete();
    step_worked = 1'b0;
    pal_eff = (m_pal > PaletteMax) ? PaletteMax : m_pal;
    if (it.block_start) begin
      acc_m    = '0;
      grp_pos  = '0;
      idx_done = '0;
      blk_done = 1'b0;
    end
    if (blk_done) return;
    step_worked = 1'b1;
    // A zero palette fails before the count is looked at.
    if (pal_eff == '0) begin
      step_q.push_back(mk('0, STATUS_RANGE, 1'b1));
      blk_done = 1'b1;
      return;
    end
    if (idx_done >= m_count) begin
      blk_done = 1'b1;
      return;
    end
    grp   = {25'd0, it.data_byte[6:0]};
    acc_m = acc_m | (grp << (7 * grp_pos));
    if (!it.data_byte[7]) begin
      v       = acc_m;
      acc_m   = '0;
      grp_pos = '0;
      if (v >= {15'd0, pal_eff}) begin
        step_q.push_back(mk('0, STATUS_RANGE, 1'b1));
        blk_done = 1'b1;
        return;
      end
      idx_done = idx_done + 24'd1;
      if (idx_done == m_count) begin
        step_q.push_back(mk(v[15:0], STATUS_INDEX, 1'b1));
        blk_done = 1'b1;
        return;
      end
      step_q.push_back(mk(v[15:0], STATUS_INDEX, 1'b0));
    end else if (grp_pos >= MaxPos) begin
      step_q.push_back(mk('0, STATUS_OVERFLOW, 1'b1));
      blk_done = 1'b1;
      return;
    end else begin
      grp_pos = grp_pos + 3'd1;
    end
    // The data ran out before the block was complete.
    if (it.end_of_data) begin
      step_q.push_back(mk('0, STATUS_TRUNCATED, 1'b1));
      blk_done = 1'b1;
    end
  endfunction

  function void note_fault(string what, out_item_t e, out_item_t g);
    faults++;
    if (faults <= ReportLimit)
      $display("%0t: %s: expected index %0d status %0d last %0d, got index %0d status %0d last %0d",
               $time, what, e.palette_index, e.status, e.last,
               g.palette_index, g.status, g.last);
  endfunction

  // Monitor: register writes, accepted bytes, results and the watchdog.
  always @(posedge clk) begin : monitor
    typed_t    tr;
    out_item_t exp_r;
    bit        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready_o) begin
        moved = 1'b1;
        case (cfg_index)
          CFG_INDEX_COUNT:     m_count = cfg_data[23:0];
          CFG_PALETTE_ENTRIES: m_pal   = cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready_o) begin
        moved = 1'b1;
        bytes_taken++;
        decode_byte(in_item);
        if (step_worked) worked_items++;
        tr = typed_q.pop_front();
        if (tr.n < 0) begin
          foreach (step_q[k]) decoded_q.push_back(step_q[k]);
        end else begin
          if (tr.n > 0) decoded_q.push_back(tr.r0);
          if (tr.n > 1) decoded_q.push_back(tr.r1);
        end
      end
      if (out_valid_o && out_ready) begin
        moved = 1'b1;
        results_seen++;
        if (decoded_q.size() == 0) begin
          note_fault("result with none pending", '0, out_item_o);
        end else begin
          exp_r = decoded_q.pop_front();
          status_seen[exp_r.status]++;
          if (out_item_o.palette_index !== exp_r.palette_index ||
              out_item_o.status !== exp_r.status ||
              out_item_o.last !== exp_r.last)
            note_fault("result differs", exp_r, out_item_o);
        end
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("Timeout: no handshake for %0d cycles, %0d results pending",
                   stall_cycles, decoded_q.size());
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HoldCycles;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_idle_on && $urandom_range(99) < 7);
    end
  end

  // Offers one byte and returns at the falling edge after it is taken.
  task automatic push_byte(input in_item_t it, input int n = -1,
                           input out_item_t r0 = '0, input out_item_t r1 = '0);
    typed_t tr;
    int     gap;
    tr.n  = n;
    tr.r0 = r0;
    tr.r1 = r1;
    gap = (tx_idle_on && $urandom_range(99) < 7) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_q.push_back(tr);
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering bytes and lets every pending result drain out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Writes both registers, with random bits above each field.
  task automatic write_cfg(input logic [23:0] count, input logic [16:0] pal);
    logic [31:0] d;
    d = $urandom();
    d[23:0] = count;
    cfg_index <= CFG_INDEX_COUNT;
    cfg_data  <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    @(negedge clk);
    d = $urandom();
    d[16:0] = pal;
    cfg_index <= CFG_PALETTE_ENTRIES;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Sends a block of encoded values; a clean block keeps every value in range.
  task automatic send_block(input int nvals, input bit clean);
    logic [31:0] v;
    logic [31:0] part;
    int          lim;
    int          nb;
    bit          eod_end;
    bit          cut;
    in_item_t    it;
    lim = (m_pal > PaletteMax) ? int'(PaletteMax) : int'(m_pal);
    eod_end = !clean && ($urandom_range(1) == 1);
    for (int k = 0; k < nvals; k++) begin
      if (!clean && $urandom_range(9) == 0) v = $urandom();
      else if (!clean && $urandom_range(9) == 0) v = lim + $urandom_range(2);
      else v = (lim == 0) ? 0 : $urandom_range(lim - 1);
      nb = 1;
      while (nb < 5 && (v >> (7 * nb)) != 0) nb++;
      // Redundant zero groups now and then, and the odd overlong varint.
      if ($urandom_range(7) == 0) nb = $urandom_range(nb, 5);
      if (!clean && $urandom_range(29) == 0) nb = 6;
      // The block may end in the middle of its last varint.
      cut = eod_end && (k == nvals - 1) && (nb > 1) && ($urandom_range(3) == 0);
      if (cut) nb--;
      for (int j = 0; j < nb; j++) begin
        part = v >> (7 * j);
        it.data_byte   = {(j < nb - 1) || cut, part[6:0]};
        it.block_start = (k == 0 && j == 0);
        it.end_of_data = (eod_end && k == nvals - 1 && j == nb - 1) ||
                         (!clean && $urandom_range(49) == 0);
        push_byte(it);
      end
    end
  endtask

  task automatic send_noise();
    in_item_t it;
    int       n;
    n = $urandom_range(3, 10);
    repeat (n) begin
      it.data_byte   = 8'($urandom_range(255));
      it.block_start = ($urandom_range(7) == 0);
      it.end_of_data = ($urandom_range(7) == 0);
      push_byte(it);
    end
  endtask

  function void add_cfg(logic [23:0] count, logic [16:0] pal);
    row_t row;
    row.is_cfg = 1'b1;
    row.count  = count;
    row.pal    = pal;
    row.it     = '0;
    row.n      = 0;
    row.r0     = '0;
    row.r1     = '0;
    plan.push_back(row);
  endfunction

  function void add_byte(logic [7:0] b, bit s, bit e, int n = -1,
                         out_item_t r0 = '0, out_item_t r1 = '0);
    row_t row;
    row.is_cfg         = 1'b0;
    row.count          = '0;
    row.pal            = '0;
    row.it.data_byte   = b;
    row.it.block_start = s;
    row.it.end_of_data = e;
    row.n              = n;
    row.r0             = r0;
    row.r1             = r1;
    plan.push_back(row);
  endfunction

  initial begin
    int          random_goal;
    int          phase;
    int          phase_start;
    int          nblk;
    int          nv;
    logic [23:0] c;
    logic [16:0] p;

    // Directed table. After reset the palette is zero, so the first byte fails.
    add_byte(8'h05, 0, 0, 1, mk('0, STATUS_RANGE, 1'b1));
    add_byte(8'hFF, 0, 1, 0);
    add_cfg(24'd4, 17'h10000);
    add_byte(8'h7F, 1, 0);
    // Largest index, then the first value past the palette.
    add_byte(8'hFF, 0, 0, 0);
    add_byte(8'hFF, 0, 0, 0);
    add_byte(8'h03, 0, 0, 1, mk(16'hFFFF, STATUS_INDEX, 1'b0));
    add_byte(8'h80, 0, 0, 0);
    add_byte(8'h80, 0, 0, 0);
    add_byte(8'h04, 0, 0, 1, mk('0, STATUS_RANGE, 1'b1));
    add_byte(8'h01, 0, 1, 0);
    // Fifth byte still continued.
    add_byte(8'hFF, 1, 0, 0);
    add_byte(8'hFF, 0, 0, 0);
    add_byte(8'hFF, 0, 0, 0);
    add_byte(8'hFF, 0, 0, 0);
    add_byte(8'hFF, 0, 0, 1, mk('0, STATUS_OVERFLOW, 1'b1));
    // Truncation mid-varint, and after an index from the same byte.
    add_byte(8'h81, 1, 1, 1, mk('0, STATUS_TRUNCATED, 1'b1));
    add_byte(8'h02, 1, 1, 2, mk(16'd2, STATUS_INDEX, 1'b0),
             mk('0, STATUS_TRUNCATED, 1'b1));
    // Oversized palette and a count of one.
    add_cfg(24'd1, 17'h1FFFF);
    add_byte(8'h00, 1, 0, 1, mk('0, STATUS_INDEX, 1'b1));
    add_byte(8'h00, 0, 0, 0);
    add_cfg(24'd0, 17'd100);
    add_byte(8'h05, 1, 0, 0);
    add_cfg(24'd0, 17'd0);
    add_byte(8'h05, 1, 0, 1, mk('0, STATUS_RANGE, 1'b1));
    // Bits above bit 31 are lost; largest count, smallest palette.
    add_cfg(24'hFFFFFF, 17'd1);
    add_byte(8'h80, 1, 0);
    add_byte(8'h80, 0, 0);
    add_byte(8'h80, 0, 0);
    add_byte(8'h80, 0, 0);
    add_byte(8'h10, 0, 0);
    add_byte(8'h01, 0, 0, 1, mk('0, STATUS_RANGE, 1'b1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        wait_idle();
        write_cfg(plan[r].count, plan[r].pal);
      end else begin
        push_byte(plan[r].it, plan[r].n, plan[r].r0, plan[r].r1);
      end
    end

    // Random phases, each under its own register setting, until about 400 bytes in all.
    random_goal = 400;
    phase = 0;
    while (bytes_taken < random_goal) begin
      case (phase)
        0: begin c = 24'($urandom_range(1, 6)); p = 17'd1; end
        1: begin c = 24'd0; p = 17'($urandom_range(1, 65536)); end
        2: begin c = 24'hFFFFFF; p = 17'h10000; end
        3: begin c = 24'd3; p = 17'h1FFFF; end
        4: begin c = 24'($urandom_range(1, 8)); p = 17'd0; end
        default: begin
          case ($urandom_range(9))
            0:       c = 24'd0;
            1:       c = 24'hFFFFFF;
            2:       c = 24'($urandom());
            default: c = 24'($urandom_range(1, 8));
          endcase
          case ($urandom_range(9))
            0:       p = 17'd0;
            1:       p = 17'd1;
            2:       p = 17'h10000;
            3:       p = 17'($urandom_range(17'h10001, 17'h1FFFF));
            4, 5:    p = 17'($urandom_range(1, 300));
            default: p = 17'($urandom_range(1, 65536));
          endcase
        end
      endcase
      // A stretch without any idling on either side.
      tx_idle_on = !(phase == 3 || phase == 4);
      rx_idle_on = tx_idle_on;
      wait_idle();
      write_cfg(c, p);
      if (phase == 2) begin
        // Hold the result side off while bytes keep coming, then drain fully.
        rx_hold_req = 1'b1;
        send_block(30, 1'b1);
        wait_idle();
      end
      phase_start = bytes_taken;
      nblk = 0;
      while (bytes_taken - phase_start < 50 && nblk < 12 && bytes_taken < random_goal) begin
        if (m_count == 0) nv = $urandom_range(1, 3);
        else if (m_count < 10) nv = int'(m_count) + $urandom_range(0, 2);
        else nv = $urandom_range(1, 12);
        if ($urandom_range(9) == 0) send_noise();
        else send_block(nv, 1'b0);
        nblk++;
      end
      phase++;
    end

    wait_idle();
    $display("Accepted %0d bytes (%0d decoded, rest ignored) under %0d register settings.",
             bytes_taken, worked_items, settings_used);
    $display("Checked %0d results: %0d indices, %0d truncations, %0d overflows, %0d range errors; %0d faults.",
             results_seen, status_seen[STATUS_INDEX], status_seen[STATUS_TRUNCATED],
             status_seen[STATUS_OVERFLOW], status_seen[STATUS_RANGE], faults);
    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
